// File: hw/rtl/qau_pkg.sv
// Shared types, widths and operand decode for the quaternion arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

  // Component format: signed fixed point.
  localparam int COMP_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Multiplier operand carries one extra bit: each component is sign-extended by one bit.
  localparam int OPW   = COMP_WIDTH + 1;
  localparam int PW    = 2 * OPW;   // exact product
  localparam int PAIRW = PW + 1;    // sum of two signed products
  localparam int SUMW  = PW + 2;    // sum of four signed products
  localparam int NUM_LANES = 4;

  // Fixed-point one, used to pass linear operations through the multipliers.
  localparam logic [OPW-1:0] ONE = {{(OPW-1){1'b0}}, 1'b1} << FRAC_BITS;

  // Subtracted terms of the Hamilton product, [lane][term].
  localparam logic [NUM_LANES-1:0][NUM_LANES-1:0] HAM_NEG =
    {4'b0100, 4'b0010, 4'b1000, 4'b1110};

  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_SUB   = 3'd1,
    FN_MUL   = 3'd2,
    FN_CONJ  = 3'd3,
    FN_NORM  = 3'd4,
    FN_SQR   = 3'd5,
    FN_VEC   = 3'd6,
    FN_SCALE = 3'd7
  } func_e;

  typedef logic [NUM_LANES-1:0][COMP_WIDTH-1:0] comp_vec_t;

  // Four product terms for one lane; each term is x*y, optionally subtracted.
  typedef struct packed {
    logic [NUM_LANES-1:0][OPW-1:0] x;
    logic [NUM_LANES-1:0][OPW-1:0] y;
    logic [NUM_LANES-1:0]          neg;
  } lane_ops_t;

  // Pipeline load enables handed to each lane.
  typedef struct packed {
    logic en_mul;
    logic en_pair;
  } lane_ctrl_t;

  // Map the operation onto a sum of up to four signed products for one lane.
  function automatic lane_ops_t lane_decode(func_e fn, logic [1:0] lane,
                                            comp_vec_t a, comp_vec_t b);
    lane_ops_t      o;
    logic [OPW-1:0] ax [NUM_LANES];
    logic [OPW-1:0] bx [NUM_LANES];
    o = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      ax[k] = {a[k][COMP_WIDTH-1], a[k]};
      bx[k] = {b[k][COMP_WIDTH-1], b[k]};
    end
    unique case (fn)
      FN_ADD: begin
        o.x[0] = ax[lane]; o.y[0] = ONE;
        o.x[1] = bx[lane]; o.y[1] = ONE;
      end
      FN_SUB: begin
        o.x[0] = ax[lane]; o.y[0] = ONE;
        o.x[1] = bx[lane]; o.y[1] = ONE;
        o.neg[1] = 1'b1;
      end
      FN_MUL: begin
        for (int k = 0; k < NUM_LANES; k++) begin
          o.x[k]   = ax[k];
          o.y[k]   = bx[lane ^ k[1:0]];
          o.neg[k] = HAM_NEG[lane][k];
        end
      end
      FN_CONJ: begin
        o.x[0] = ax[lane]; o.y[0] = ONE;
        o.neg[0] = (lane != 2'd0);
      end
      FN_NORM: begin
        if (lane == 2'd0) begin
          for (int k = 0; k < NUM_LANES; k++) begin
            o.x[k] = ax[k];
            o.y[k] = ax[k];
          end
        end
      end
      FN_SQR: begin
        if (lane == 2'd0) begin
          for (int k = 0; k < NUM_LANES; k++) begin
            o.x[k]   = ax[k];
            o.y[k]   = ax[k];
            o.neg[k] = (k != 0);
          end
        end else begin
          // doubled cross term: two identical products
          o.x[0] = ax[0]; o.y[0] = ax[lane];
          o.x[1] = ax[0]; o.y[1] = ax[lane];
        end
      end
      FN_VEC: begin
        if (lane != 2'd0) begin
          o.x[0] = ax[lane]; o.y[0] = ONE;
        end
      end
      FN_SCALE: begin
        o.x[0] = ax[lane]; o.y[0] = bx[0];
      end
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qau_lane.sv
// One component lane: four multipliers, pairwise sums, final sum, shift and saturate.
`timescale 1ns / 1ps
`default_nettype none

module qau_lane import qau_pkg::*; (
  input  wire logic                  clk_i,
  input  wire lane_ctrl_t            ctrl_i,
  input  wire lane_ops_t             ops_i,
  output logic [COMP_WIDTH-1:0]      res_o,
  output logic                       ovf_o
);

  logic signed [PW-1:0]    prod_d [NUM_LANES];
  logic signed [PW-1:0]    prod_q [NUM_LANES];
  logic [NUM_LANES-1:0]    neg_q;
  logic signed [PAIRW-1:0] term   [NUM_LANES];
  logic signed [PAIRW-1:0] pair_d [2];
  logic signed [PAIRW-1:0] pair_q [2];
  logic signed [SUMW-1:0]  sum;
  logic signed [SUMW-1:0]  shifted;
  logic [SUMW-COMP_WIDTH:0] top_bits;

  // Stage 1: exact products
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      prod_d[k] = $signed(ops_i.x[k]) * $signed(ops_i.y[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_mul) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        prod_q[k] <= prod_d[k];
      end
      neg_q <= ops_i.neg;
    end
  end

  // Stage 2: apply signs, add in pairs
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      term[k] = neg_q[k] ? -{prod_q[k][PW-1], prod_q[k]} : {prod_q[k][PW-1], prod_q[k]};
    end
    pair_d[0] = term[0] + term[1];
    pair_d[1] = term[2] + term[3];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_pair) begin
      pair_q[0] <= pair_d[0];
      pair_q[1] <= pair_d[1];
    end
  end

  // Stage 3: final sum, floor shift, saturate (registered in the merge stage)
  assign sum      = {pair_q[0][PAIRW-1], pair_q[0]} + {pair_q[1][PAIRW-1], pair_q[1]};
  assign shifted  = sum >>> FRAC_BITS;
  assign top_bits = shifted[SUMW-1:COMP_WIDTH-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      res_o = shifted[COMP_WIDTH-1:0];
      ovf_o = 1'b0;
    end else begin
      res_o = shifted[SUMW-1] ? {1'b1, {(COMP_WIDTH-1){1'b0}}}
                              : {1'b0, {(COMP_WIDTH-1){1'b1}}};
      ovf_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qau_merge.sv
// Output stage: gathers lane results, combines overflow flags, holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module qau_merge import qau_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire comp_vec_t             res_i,
  input  wire logic [NUM_LANES-1:0]  ovf_i,
  output logic                       valid_o,
  input  wire logic                  stall_i,
  output comp_vec_t                  res_o,
  output logic                       ovf_o
);

  logic      valid_q;
  comp_vec_t res_q;
  logic      ovf_q;

  // Register frees when empty or when the downstream takes it
  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
      ovf_q <= |ovf_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign ovf_o   = ovf_q;

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_arithmetic_unit.sv
// Top level of the quaternion arithmetic unit: decode, four component lanes, merge.
//
//   Channel  Direction  Handshake          Payload
//   input    in         valid_i / stall_o  func_i, a_{w,x,y,z}_i, b_{w,x,y,z}_i
//   output   out        valid_o / stall_i  r_{w,x,y,z}_o, overflow_o
//
// One transaction per cycle while stall_i is low; an accepted input goes through the
// multiplier stage, pair-sum stage and sum/shift/saturate into the output register.
// Each stage loads when empty or when the stage after it moves, so bubbles close up
// and an input is taken while a finished result waits. The 33x33 multipliers set
// the cycle time. Reset clears only the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit import qau_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       stall_o,
  input  wire logic [2:0]            func_i,
  input  wire logic [COMP_WIDTH-1:0] a_w_i,
  input  wire logic [COMP_WIDTH-1:0] a_x_i,
  input  wire logic [COMP_WIDTH-1:0] a_y_i,
  input  wire logic [COMP_WIDTH-1:0] a_z_i,
  input  wire logic [COMP_WIDTH-1:0] b_w_i,
  input  wire logic [COMP_WIDTH-1:0] b_x_i,
  input  wire logic [COMP_WIDTH-1:0] b_y_i,
  input  wire logic [COMP_WIDTH-1:0] b_z_i,
  output logic                       valid_o,
  input  wire logic                  stall_i,
  output logic [COMP_WIDTH-1:0]      r_w_o,
  output logic [COMP_WIDTH-1:0]      r_x_o,
  output logic [COMP_WIDTH-1:0]      r_y_o,
  output logic [COMP_WIDTH-1:0]      r_z_o,
  output logic                       overflow_o
);

  comp_vec_t            a_vec;
  comp_vec_t            b_vec;
  comp_vec_t            lane_res;
  comp_vec_t            out_res;
  logic [NUM_LANES-1:0] lane_ovf;
  lane_ctrl_t           ctrl;
  logic                 mul_valid_q;
  logic                 pair_valid_q;
  logic                 rdy_mul;
  logic                 rdy_pair;
  logic                 rdy_out;

  assign a_vec = {a_z_i, a_y_i, a_x_i, a_w_i};
  assign b_vec = {b_z_i, b_y_i, b_x_i, b_w_i};

  // Stage ready chain
  assign rdy_pair = !pair_valid_q || rdy_out;
  assign rdy_mul  = !mul_valid_q || rdy_pair;
  assign stall_o  = !rdy_mul;

  assign ctrl.en_mul  = rdy_mul && valid_i;
  assign ctrl.en_pair = rdy_pair && mul_valid_q;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q  <= 1'b0;
      pair_valid_q <= 1'b0;
    end else begin
      if (rdy_mul) begin
        mul_valid_q <= valid_i;
      end
      if (rdy_pair) begin
        pair_valid_q <= mul_valid_q;
      end
    end
  end

  // One lane per result component
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    qau_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .ops_i  (lane_decode(func_e'(func_i), 2'(l), a_vec, b_vec)),
      .res_o  (lane_res[l]),
      .ovf_o  (lane_ovf[l])
    );
  end

  qau_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pair_valid_q),
    .ready_o (rdy_out),
    .res_i   (lane_res),
    .ovf_i   (lane_ovf),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .res_o   (out_res),
    .ovf_o   (overflow_o)
  );

  assign r_w_o = out_res[0];
  assign r_x_o = out_res[1];
  assign r_y_o = out_res[2];
  assign r_z_o = out_res[3];

endmodule

`default_nettype wire
